FILE: src/pbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbr_pkg;
    localparam int POS_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_NONE     = 2'd0;
    localparam t_mode MODE_PERIODIC = 2'd1;
    localparam t_mode MODE_ELASTIC  = 2'd2;
    localparam t_mode MODE_DIFFUSE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd6;

    localparam logic signed [POS_WIDTH-1:0] BOUND_MAX_RST =
        POS_WIDTH'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [POS_WIDTH-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] new_x;
        logic signed [POS_WIDTH-1:0] new_y;
        logic signed [POS_WIDTH-1:0] new_z;
        logic                        delete_flag;
        logic                        status;
    } t_out;

    typedef logic signed [POS_WIDTH-1:0] t_bnd [NUM_AXES];

    // one axis of classified work
    typedef struct packed {
        logic [POS_WIDTH-1:0] p;
        logic [POS_WIDTH-1:0] lo;
        logic [POS_WIDTH-1:0] hi;
        logic [POS_WIDTH-1:0] d;
        logic [POS_WIDTH-1:0] len;
        logic                 fold;
        logic                 above;
    } t_axis_job;

    typedef struct packed {
        t_mode                    mode;
        logic                     del;
        t_axis_job [NUM_AXES-1:0] ax;
    } t_job;
endpackage
`default_nettype wire

FILE: src/particle_boundary_resolve_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                                  | handshake
// ----------+----------------------------------------+---------------------------
// input     | i_start, o_busy, i_item                | taken when start & !busy
// result    | o_valid, o_result                      | one-cycle strobe, no stall
// config    | i_cfg_we, i_cfg_idx, i_cfg_data        | written when we is high
//
// one item per cycle sustained; items pass through classify, queue, 32-stage
// restoring divider giving quotient parity and remainder, and final select
// reset is synchronous, active low; registers return to mode none, unit box
// busy rises only if the classify queue is full, which a steady stream never
// reaches because the divider drains it every cycle
module particle_boundary_resolve_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    output logic                                o_busy,
    input  pbr_pkg::t_in                        i_item,
    output logic                                o_valid,
    output pbr_pkg::t_out                       o_result,
    input  wire                                 i_cfg_we,
    input  wire  [pbr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [pbr_pkg::POS_WIDTH-1:0]       i_cfg_data
);
    import pbr_pkg::*;

    // configuration registers
    t_mode r_mode;
    t_bnd  r_lo;
    t_bnd  r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= BOUND_MAX_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_MIN_X: r_lo[0] <= i_cfg_data;
                REG_MAX_X: r_hi[0] <= i_cfg_data;
                REG_MIN_Y: r_lo[1] <= i_cfg_data;
                REG_MAX_Y: r_hi[1] <= i_cfg_data;
                REG_MIN_Z: r_lo[2] <= i_cfg_data;
                REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default:   ; // unused index, write dropped
            endcase
        end
    end

    logic w_accept;
    logic w_fv;
    t_job w_fjob;
    logic w_qne;
    logic w_qfull;
    t_job w_qjob;

    assign w_accept = i_start && !w_qfull;
    assign o_busy   = w_qfull;

    // front: classify each axis, form distance and box length
    pbr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_item  (i_item),
        .i_mode  (r_mode),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_valid (w_fv),
        .o_job   (w_fjob)
    );

    // short queue decoupling classify from the divider
    pbr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_fv),
        .i_job      (w_fjob),
        .i_pop      (1'b1),
        .o_nonempty (w_qne),
        .o_full     (w_qfull),
        .o_job      (w_qjob)
    );

    // back: divide, then wrap or reflect
    pbr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qne),
        .i_job    (w_qjob),
        .o_valid  (o_valid),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

FILE: src/pbr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pbr_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  pbr_pkg::t_in        i_item,
    input  pbr_pkg::t_mode      i_mode,
    input  pbr_pkg::t_bnd       i_lo,
    input  pbr_pkg::t_bnd       i_hi,
    output logic                o_valid,
    output pbr_pkg::t_job       o_job
);
    import pbr_pkg::*;

    logic signed [POS_WIDTH-1:0] w_pos [NUM_AXES];
    t_job                        n_job;
    t_job                        r_job;
    logic                        r_valid;

    assign w_pos[0] = i_item.pos_x;
    assign w_pos[1] = i_item.pos_y;
    assign w_pos[2] = i_item.pos_z;

    always_comb begin
        logic out_hi, out_lo, any_out;
        any_out = 1'b0;
        n_job   = '0;
        n_job.mode = i_mode;
        for (int a = 0; a < NUM_AXES; a++) begin
            out_hi = w_pos[a] > i_hi[a];
            out_lo = i_lo[a] > w_pos[a];
            any_out = any_out | out_hi | out_lo;
            n_job.ax[a].p     = w_pos[a];
            n_job.ax[a].lo    = i_lo[a];
            n_job.ax[a].hi    = i_hi[a];
            n_job.ax[a].len   = i_hi[a] - i_lo[a];
            n_job.ax[a].above = out_hi;
            n_job.ax[a].d     = out_hi ? w_pos[a] - i_lo[a] : i_lo[a] - w_pos[a];
            n_job.ax[a].fold  = (i_hi[a] > i_lo[a]) && (out_hi || out_lo) &&
                                ((i_mode == MODE_PERIODIC) || (i_mode == MODE_ELASTIC));
        end
        n_job.del = (i_mode == MODE_DIFFUSE) && any_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

FILE: src/pbr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pbr_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  pbr_pkg::t_job       i_job,
    input  wire                 i_pop,
    output logic                o_nonempty,
    output logic                o_full,
    output pbr_pkg::t_job       o_job
);
    import pbr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_nonempty = r_cnt != 2'd0;
    assign o_full     = r_cnt == 2'd2;
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

FILE: src/pbr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pbr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  pbr_pkg::t_job       i_job,
    output logic                o_valid,
    output pbr_pkg::t_out       o_result
);
    import pbr_pkg::*;

    localparam int NSTG = POS_WIDTH;

    // restoring divider, one quotient bit per stage and axis
    logic                       r_v   [NSTG+1];
    t_job                       r_job [NSTG+1];
    logic [POS_WIDTH-1:0]       r_rem [NSTG+1][NUM_AXES];
    logic [POS_WIDTH-1:0]       r_dvd [NSTG+1][NUM_AXES];
    logic                       r_qb  [NSTG+1][NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_job[0] <= i_job;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_rem[0][a] <= '0;
            r_dvd[0][a] <= i_job.ax[a].d;
            r_qb[0][a]  <= 1'b0;
        end
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        always_ff @(posedge i_clk) begin
            logic [POS_WIDTH:0] t;
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_job[s+1] <= r_job[s];
            for (int a = 0; a < NUM_AXES; a++) begin
                t = {r_rem[s][a], r_dvd[s][a][POS_WIDTH-1]};
                if (t >= {1'b0, r_job[s].ax[a].len}) begin
                    r_rem[s+1][a] <= POS_WIDTH'(t - {1'b0, r_job[s].ax[a].len});
                    r_qb[s+1][a]  <= 1'b1;
                end else begin
                    r_rem[s+1][a] <= t[POS_WIDTH-1:0];
                    r_qb[s+1][a]  <= 1'b0;
                end
                r_dvd[s+1][a] <= {r_dvd[s][a][POS_WIDTH-2:0], 1'b0};
            end
        end
    end

    logic [POS_WIDTH-1:0] w_new [NUM_AXES];
    t_job                 w_job;
    t_out                 r_out;
    logic                 r_ov;

    assign w_job = r_job[NSTG];

    always_comb begin
        logic use_hi;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (w_job.mode == MODE_PERIODIC) begin
                use_hi = !w_job.ax[a].above;
            end else begin
                use_hi = r_qb[NSTG][a];
            end
            if (!w_job.ax[a].fold) begin
                w_new[a] = w_job.ax[a].p;
            end else if (use_hi) begin
                w_new[a] = w_job.ax[a].hi - r_rem[NSTG][a];
            end else begin
                w_new[a] = w_job.ax[a].lo + r_rem[NSTG][a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NSTG];
        end
        r_out.new_x       <= w_new[0];
        r_out.new_y       <= w_new[1];
        r_out.new_z       <= w_new[2];
        r_out.delete_flag <= w_job.del;
        r_out.status      <= w_job.del;
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;
endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pbr_pkg::*;

    localparam int LATENCY   = 36;
    localparam int WDOG_LIM  = 2000;
    localparam int N_RANDOM  = 1750;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef logic signed [POS_WIDTH-1:0] t_pos;

    // one pending action for the driver: a config write or an item
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [POS_WIDTH-1:0] data;
        t_in                  item;
    } t_action;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    t_in  i_item = '0;
    logic o_valid;
    t_out o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [POS_WIDTH-1:0] i_cfg_data = '0;

    particle_boundary_resolve_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers, updated when the driver issues a write
    t_mode mdl_mode = MODE_NONE;
    t_pos  mdl_lo [NUM_AXES] = '{default: '0};
    t_pos  mdl_hi [NUM_AXES] = '{default: BOUND_MAX_RST};

    t_action pending_q [$];
    t_out    expected_q [$];
    int      mismatches = 0;
    int      wdog = 0;

    // reflect or wrap one coordinate into [lo, hi]
    function automatic t_pos fold_coord(t_pos p, t_pos lo, t_pos hi, t_mode m);
        logic [POS_WIDTH-1:0] len, offs, quo, rem;
        logic above;
        if (!(hi > lo)) return p;
        len = hi - lo;
        if (p > hi) begin
            above = 1'b1;
            offs = p - lo;
        end else if (lo > p) begin
            above = 1'b0;
            offs = lo - p;
        end else begin
            return p;
        end
        quo = offs / len;
        rem = offs % len;
        if (m == MODE_PERIODIC) return above ? t_pos'(lo + rem) : t_pos'(hi - rem);
        return quo[0] ? t_pos'(hi - rem) : t_pos'(lo + rem);
    endfunction

    function automatic t_out resolve_position(t_in it);
        t_out r;
        t_pos p [NUM_AXES];
        logic del;
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        del = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (mdl_mode == MODE_PERIODIC || mdl_mode == MODE_ELASTIC)
                p[a] = fold_coord(p[a], mdl_lo[a], mdl_hi[a], mdl_mode);
            else if (mdl_mode == MODE_DIFFUSE && (p[a] > mdl_hi[a] || mdl_lo[a] > p[a]))
                del = 1'b1;
        end
        r.new_x = p[0];
        r.new_y = p[1];
        r.new_z = p[2];
        r.delete_flag = del;
        r.status = del;
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [POS_WIDTH-1:0] d);
        case (idx)
            REG_MODE:  mdl_mode  = t_mode'(d[1:0]);
            REG_MIN_X: mdl_lo[0] = d;
            REG_MAX_X: mdl_hi[0] = d;
            REG_MIN_Y: mdl_lo[1] = d;
            REG_MAX_Y: mdl_hi[1] = d;
            REG_MIN_Z: mdl_lo[2] = d;
            REG_MAX_Z: mdl_hi[2] = d;
            default: ;
        endcase
    endfunction

    // coordinates biased toward the bounds and the box so folding is exercised
    function automatic t_pos rand_coord(t_pos lo, t_pos hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2: return lo + t_pos'($urandom_range(0, 3)) - 1;
            3: return hi + t_pos'($urandom_range(0, 3)) - 1;
            4: return hi + (hi - lo) * t_pos'($urandom_range(0, 5));
            5: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_pos'($urandom);
        endcase
    endfunction

    // random bound pair, mostly small boxes, sometimes degenerate or huge
    function automatic void rand_bounds(output t_pos lo, output t_pos hi);
        case ($urandom_range(0, 9))
            0: begin lo = 32'sh80000000; hi = 32'sh7fffffff; end
            1: begin lo = t_pos'($urandom); hi = lo - t_pos'($urandom_range(0, 100)); end
            2: begin lo = t_pos'($urandom); hi = lo + 1; end
            default: begin
                lo = t_pos'($urandom_range(0, 1 << 20)) - (1 << 19);
                hi = lo + t_pos'($urandom_range(1, 1 << 20));
            end
        endcase
    endfunction

    // driver: pops queued actions, random gaps; config only when pipeline is empty
    int gap = 0;
    int drain = 0;
    always @(posedge i_clk) begin
        logic drv_start;
        logic drv_we;
        if (i_rst_n) begin
            drv_start = i_start;
            drv_we    = 1'b0;
            if (i_start && !o_busy) begin
                expected_q.push_back(resolve_position(i_item));
                drv_start = 1'b0;
            end
            if (!(i_start && o_busy) && pending_q.size() != 0) begin
                if (pending_q[0].is_cfg) begin
                    drv_start = 1'b0;
                    if (expected_q.size() != 0 || (i_start && !o_busy)) begin
                        drain = 0;
                    end else if (drain < 4) begin
                        drain++;
                    end else begin
                        drv_we      = 1'b1;
                        i_cfg_idx  <= pending_q[0].idx;
                        i_cfg_data <= pending_q[0].data;
                        apply_cfg(pending_q[0].idx, pending_q[0].data);
                        void'(pending_q.pop_front());
                        drain = 0;
                    end
                end else if (gap > 0) begin
                    gap--;
                    drv_start = 1'b0;
                end else begin
                    drv_start = 1'b1;
                    i_item   <= pending_q[0].item;
                    void'(pending_q.pop_front());
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            i_start  <= drv_start;
            i_cfg_we <= drv_we;
        end
    end

    // monitor: results are one-cycle strobes compared against the oldest item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid || (i_start && !o_busy) || i_cfg_we) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_result);
                end else begin
                    t_out e;
                    e = expected_q.pop_front();
                    if (o_result.new_x !== e.new_x || o_result.new_y !== e.new_y ||
                        o_result.new_z !== e.new_z ||
                        o_result.delete_flag !== e.delete_flag ||
                        o_result.status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", e, o_result);
                    end
                end
            end
            if (wdog >= WDOG_LIM) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [POS_WIDTH-1:0] d);
        t_action a;
        a = '0;
        a.is_cfg = 1'b1;
        a.idx = idx;
        a.data = d;
        pending_q.push_back(a);
    endtask

    task automatic queue_item(t_pos x, t_pos y, t_pos z);
        t_action a;
        a = '0;
        a.item.pos_x = x;
        a.item.pos_y = y;
        a.item.pos_z = z;
        pending_q.push_back(a);
    endtask

    // shadow of the bounds as queued, used to aim random coordinates
    t_pos plan_lo [NUM_AXES];
    t_pos plan_hi [NUM_AXES];

    initial begin
        t_pos lo, hi;
        int n;
        // directed: reset box, then every mode on the unit box with edge values
        queue_item(0, 32'sh10000, 32'sh7fffffff);
        queue_item(32'sh80000000, -1, 32'sh30000);
        for (int m = 1; m < 4; m++) begin
            queue_cfg(REG_MODE, m);
            queue_item(0, 32'sh10000, 32'sh8000);
            queue_item(32'sh30000, -32'sh20000, 32'sh7fffffff);
            queue_item(32'sh28000, -32'sh18000, 32'sh80000000);
            queue_item(32'sh10001, -1, 32'sh20000);
        end
        // degenerate axes: x zero length, y inverted
        queue_cfg(REG_MIN_X, 32'sh10000);
        queue_cfg(REG_MAX_Y, -32'sh10000);
        queue_item(32'sh20000, 32'sh20000, 32'sh20000);
        queue_cfg(REG_MODE, MODE_ELASTIC);
        queue_item(32'sh20000, -32'sh20000, 32'sh50000);
        queue_cfg(REG_MODE, MODE_PERIODIC);
        queue_item(32'sh20000, -32'sh20000, -32'sh50000);
        // full range z axis
        queue_cfg(REG_MIN_Z, 32'h80000000);
        queue_cfg(REG_MAX_Z, 32'h7fffffff);
        queue_item(0, 0, 32'sh80000000);
        for (int a = 0; a < NUM_AXES; a++) begin
            plan_lo[a] = (a == 2) ? 32'sh80000000 : (a == 0 ? 32'sh10000 : 0);
            plan_hi[a] = (a == 2) ? 32'sh7fffffff : (a == 1 ? -32'sh10000 : 32'sh10000);
        end
        // random phases: new mode and bounds, then a burst of items
        n = 0;
        while (n < N_RANDOM) begin
            queue_cfg(REG_MODE, $urandom_range(0, 3));
            for (int a = 0; a < NUM_AXES; a++) begin
                if ($urandom_range(0, 2) != 0) begin
                    rand_bounds(lo, hi);
                    plan_lo[a] = lo;
                    plan_hi[a] = hi;
                    queue_cfg(CFG_IDX_W'(REG_MIN_X + 2 * a), lo);
                    queue_cfg(CFG_IDX_W'(REG_MAX_X + 2 * a), hi);
                end
            end
            if ($urandom_range(0, 15) == 0) queue_cfg(REG_UNUSED, $urandom);
            for (int k = $urandom_range(10, 60); k > 0; k--) begin
                queue_item(rand_coord(plan_lo[0], plan_hi[0]),
                           rand_coord(plan_lo[1], plan_hi[1]),
                           rand_coord(plan_lo[2], plan_hi[2]));
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        wait (expected_q.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
